### hdl/animation_progress_sequencer_top_defines.svh
// Assertion macros for the animation progress sequencer.
// Used by the sequencer module; no other dependencies.
`ifndef ANIMATION_PROGRESS_SEQUENCER_TOP_DEFINES_SVH
`define ANIMATION_PROGRESS_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define APS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define APS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/aps_pkg.sv
// Package for the animation progress sequencer: codes, state types and
// the request struct between the sequencer and the arithmetic unit. No dependencies.
`timescale 1ns / 1ps

package aps_pkg;

  localparam int LEN_W = 20;
  localparam int CFG_W = 20;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_COND    = 3'd1,
    OP_INIT    = 3'd2,
    OP_QUEUE   = 3'd3,
    OP_RETIRE  = 3'd4,
    OP_RESET   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    PH_NONE    = 2'd0,
    PH_DELAYED = 2'd1,
    PH_RUNNING = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REP_NONE  = 2'd0,
    REP_PULSE = 2'd1,
    REP_LOOP  = 2'd2
  } repeat_t;

  typedef enum logic [1:0] {
    REG_RUN_LENGTH  = 2'd0,
    REG_START_DELAY = 2'd1,
    REG_REPEAT_MODE = 2'd2,
    REG_REVERSIBLE  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_QUEUE,
    SEQ_MUL,
    SEQ_EVAL,
    SEQ_DIV,
    SEQ_FINISH
  } seq_state_t;

  typedef enum logic {
    AU_MUL = 1'b0,
    AU_DIV = 1'b1
  } arith_mode_t;

  typedef struct packed {
    logic        start;
    arith_mode_t mode;
  } arith_req_t;

endpackage

### hdl/aps_arith_unit.sv
// Shared bit-serial arithmetic unit: shift-add multiply and restoring divide
// on one adder, one bit per cycle. Depends on aps_pkg.
`timescale 1ns / 1ps

module aps_arith_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  aps_pkg::arith_req_t               req,
  input  logic [aps_pkg::LEN_W-1:0]         len,
  input  logic [FRACTION_BITS:0]            frac_in,
  input  logic [aps_pkg::LEN_W-1:0]         num_in,
  output logic                              done,
  output logic [aps_pkg::LEN_W-1:0]         product,
  output logic [FRACTION_BITS:0]            quotient
);

  localparam int PW    = FRACTION_BITS + 1;
  localparam int LW    = aps_pkg::LEN_W;
  localparam int ACC_W = LW + PW;
  localparam int AW    = ACC_W + 1;
  localparam int CNT_W = $clog2(PW);

  logic                busy;
  aps_pkg::arith_mode_t mode;
  logic [CNT_W-1:0]    cnt;
  logic [ACC_W-1:0]    acc;
  logic [PW-1:0]       fr;
  logic [LW-1:0]       divisor;
  logic                first;

  logic [LW:0]         rem_trial;
  logic [AW-1:0]       add_a;
  logic [AW-1:0]       add_b;
  logic                add_cin;
  logic [AW-1:0]       sum;
  logic                qbit;
  logic [ACC_W-1:0]    acc_next;
  logic [PW-1:0]       fr_next;

  // shared adder
  always_comb begin
    rem_trial = first ? acc[LW:0] : {acc[LW-1:0], 1'b0};
    if (mode == aps_pkg::AU_MUL) begin
      add_a   = {1'b0, acc[ACC_W-2:0], 1'b0};
      add_b   = fr[PW-1] ? AW'(divisor) : '0;
      add_cin = 1'b0;
    end else begin
      add_a   = AW'(rem_trial);
      add_b   = ~AW'(divisor);
      add_cin = 1'b1;
    end
    sum  = add_a + add_b + AW'(add_cin);
    qbit = ~sum[AW-1];
    if (mode == aps_pkg::AU_MUL) begin
      acc_next = sum[ACC_W-1:0];
      fr_next  = {fr[PW-2:0], 1'b0};
    end else begin
      acc_next = qbit ? ACC_W'(sum[LW:0]) : ACC_W'(rem_trial);
      fr_next  = {fr[PW-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(PW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode    <= req.mode;
      divisor <= len;
      first   <= 1'b1;
      if (req.mode == aps_pkg::AU_MUL) begin
        acc <= '0;
        fr  <= frac_in;
      end else begin
        acc <= ACC_W'(num_in);
        fr  <= '0;
      end
    end else if (busy) begin
      acc   <= acc_next;
      fr    <= fr_next;
      first <= 1'b0;
    end
  end

  assign product  = acc[FRACTION_BITS +: LW];
  assign quotient = fr;

endmodule

### hdl/aps_sequencer.sv
// Sequencer for the animation progress sequencer: run state, tick steps and
// the output register. Depends on aps_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "animation_progress_sequencer_top_defines.svh"

module aps_sequencer #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   operation,
  input  logic [31:0]                  now_ms,
  input  logic                         start_request,
  input  logic                         condition,
  input  logic [1:0]                   queue_direction,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   direction,
  output logic [1:0]                   phase,
  output logic [FRACTION_BITS:0]       progress,
  output logic [1:0]                   queued,
  input  logic [aps_pkg::LEN_W-1:0]    run_length,
  input  logic [aps_pkg::LEN_W-1:0]    start_delay,
  input  aps_pkg::repeat_t             repeat_mode,
  input  logic                         reversible,
  output aps_pkg::arith_req_t          areq,
  output logic [FRACTION_BITS:0]       frac_in,
  output logic [aps_pkg::LEN_W-1:0]    num_in,
  input  logic                         adone,
  input  logic [aps_pkg::LEN_W-1:0]    product,
  input  logic [FRACTION_BITS:0]       quotient
);

  localparam int PW = FRACTION_BITS + 1;
  localparam int LW = aps_pkg::LEN_W;
  localparam logic [PW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  aps_pkg::seq_state_t state, state_next;
  logic [31:0]     start_time, start_time_next;
  logic [PW-1:0]   prog, prog_next;
  aps_pkg::dir_t   cur_dir, cur_dir_next;
  aps_pkg::dir_t   q_dir, q_dir_next;
  aps_pkg::phase_t cur_phase, cur_phase_next;
  logic            last_cond, last_cond_next;
  logic [31:0]     now_r;
  logic            start_req_r;
  logic            out_free;
  logic            accept;

  logic [31:0]     elapsed;
  logic [31:0]     past_delay;
  logic [LW:0]     ramp_end;
  logic            pulse_on;
  logic            loop_on;

  logic            arith_wait;
  logic            arith_issue;
  logic            out_load;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != aps_pkg::SEQ_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign arith_wait  = (state == aps_pkg::SEQ_MUL) || (state == aps_pkg::SEQ_DIV);
  assign arith_issue = (state == aps_pkg::SEQ_QUEUE) || (state == aps_pkg::SEQ_EVAL);
  assign out_load    = (state == aps_pkg::SEQ_FINISH) && out_free;

  assign elapsed    = now_r - start_time;
  assign past_delay = elapsed - 32'(start_delay);
  assign ramp_end   = {1'b0, run_length} + {1'b0, start_delay};
  assign pulse_on   = (repeat_mode == aps_pkg::REP_PULSE) && last_cond;
  assign loop_on    = (repeat_mode == aps_pkg::REP_LOOP) && last_cond;

  always_comb begin
    state_next      = state;
    start_time_next = start_time;
    prog_next       = prog;
    cur_dir_next    = cur_dir;
    q_dir_next      = q_dir;
    cur_phase_next  = cur_phase;
    last_cond_next  = last_cond;
    areq.start      = 1'b0;
    areq.mode       = aps_pkg::AU_MUL;
    frac_in         = (cur_dir == aps_pkg::DIR_REV) ? prog : ONE - prog;
    num_in          = (cur_dir == aps_pkg::DIR_FWD) ? past_delay[LW-1:0]
                                                    : run_length - elapsed[LW-1:0];
    case (state)
      aps_pkg::SEQ_IDLE: begin
        if (accept) begin
          state_next = aps_pkg::SEQ_FINISH;
          case (aps_pkg::op_t'(operation))
            aps_pkg::OP_TICK: begin
              state_next = aps_pkg::SEQ_QUEUE;
            end
            aps_pkg::OP_COND: begin
              if (condition && !last_cond) begin
                q_dir_next = aps_pkg::DIR_FWD;
              end else if (!condition && last_cond) begin
                if (reversible) begin
                  q_dir_next = aps_pkg::DIR_REV;
                end else begin
                  cur_dir_next   = aps_pkg::DIR_NONE;
                  q_dir_next     = aps_pkg::DIR_NONE;
                  cur_phase_next = aps_pkg::PH_NONE;
                end
              end
              last_cond_next = condition;
            end
            aps_pkg::OP_INIT: begin
              last_cond_next = condition;
              q_dir_next     = aps_pkg::DIR_NONE;
              if (!condition) begin
                cur_dir_next   = aps_pkg::DIR_NONE;
                cur_phase_next = aps_pkg::PH_NONE;
              end else if (repeat_mode == aps_pkg::REP_PULSE) begin
                prog_next      = ONE;
                cur_dir_next   = aps_pkg::DIR_REV;
                cur_phase_next = aps_pkg::PH_RUNNING;
              end else if (repeat_mode == aps_pkg::REP_LOOP) begin
                prog_next      = '0;
                cur_dir_next   = aps_pkg::DIR_FWD;
                cur_phase_next = aps_pkg::PH_RUNNING;
              end else begin
                prog_next      = ONE;
                cur_dir_next   = aps_pkg::DIR_NONE;
                cur_phase_next = aps_pkg::PH_DONE;
              end
            end
            aps_pkg::OP_QUEUE: begin
              q_dir_next = (queue_direction == aps_pkg::DIR_FWD) ? aps_pkg::DIR_FWD :
                           (queue_direction == aps_pkg::DIR_REV) ? aps_pkg::DIR_REV :
                                                                   aps_pkg::DIR_NONE;
            end
            aps_pkg::OP_RETIRE: begin
              if (cur_phase == aps_pkg::PH_DONE) begin
                cur_dir_next = aps_pkg::DIR_NONE;
                q_dir_next   = aps_pkg::DIR_NONE;
              end
            end
            aps_pkg::OP_RESET: begin
              cur_dir_next   = aps_pkg::DIR_NONE;
              q_dir_next     = aps_pkg::DIR_NONE;
              cur_phase_next = aps_pkg::PH_NONE;
            end
            default: begin
            end
          endcase
        end
      end
      aps_pkg::SEQ_QUEUE: begin
        state_next = aps_pkg::SEQ_EVAL;
        if (start_req_r || q_dir == aps_pkg::DIR_REV) begin
          q_dir_next = aps_pkg::DIR_NONE;
        end
        if (q_dir == aps_pkg::DIR_FWD) begin
          if (cur_dir == aps_pkg::DIR_REV) begin
            areq.start = 1'b1;
            state_next = aps_pkg::SEQ_MUL;
          end else begin
            start_time_next = now_r;
            cur_dir_next    = aps_pkg::DIR_FWD;
          end
        end else if (q_dir == aps_pkg::DIR_REV) begin
          if (cur_dir == aps_pkg::DIR_FWD) begin
            areq.start = 1'b1;
            state_next = aps_pkg::SEQ_MUL;
          end else begin
            if (cur_dir == aps_pkg::DIR_NONE) begin
              start_time_next = now_r;
            end
            cur_dir_next = aps_pkg::DIR_REV;
          end
        end
      end
      aps_pkg::SEQ_MUL: begin
        if (adone) begin
          // re-base keeps progress continuous across the turn
          start_time_next = now_r - 32'(product);
          cur_dir_next    = (cur_dir == aps_pkg::DIR_REV) ? aps_pkg::DIR_FWD
                                                          : aps_pkg::DIR_REV;
          state_next      = aps_pkg::SEQ_EVAL;
        end
      end
      aps_pkg::SEQ_EVAL: begin
        state_next = aps_pkg::SEQ_FINISH;
        if (cur_dir == aps_pkg::DIR_FWD) begin
          if (elapsed < 32'(start_delay)) begin
            prog_next      = '0;
            cur_phase_next = aps_pkg::PH_DELAYED;
          end else if (elapsed < 32'(ramp_end)) begin
            areq.start = 1'b1;
            areq.mode  = aps_pkg::AU_DIV;
            state_next = aps_pkg::SEQ_DIV;
          end else begin
            prog_next = ONE;
            if (pulse_on) begin
              cur_dir_next    = aps_pkg::DIR_REV;
              start_time_next = now_r;
            end else if (loop_on) begin
              prog_next       = '0;
              start_time_next = now_r;
            end else begin
              cur_phase_next = aps_pkg::PH_DONE;
            end
          end
        end else if (cur_dir == aps_pkg::DIR_REV) begin
          if (elapsed < 32'(run_length)) begin
            areq.start = 1'b1;
            areq.mode  = aps_pkg::AU_DIV;
            state_next = aps_pkg::SEQ_DIV;
          end else begin
            prog_next = '0;
            if (pulse_on) begin
              cur_dir_next    = aps_pkg::DIR_FWD;
              start_time_next = now_r;
            end else begin
              cur_phase_next = aps_pkg::PH_DONE;
            end
          end
        end
      end
      aps_pkg::SEQ_DIV: begin
        if (adone) begin
          prog_next      = quotient;
          cur_phase_next = aps_pkg::PH_RUNNING;
          state_next     = aps_pkg::SEQ_FINISH;
        end
      end
      aps_pkg::SEQ_FINISH: begin
        if (out_free) begin
          state_next = aps_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_next = aps_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= aps_pkg::SEQ_IDLE;
      start_time <= '0;
      prog       <= '0;
      cur_dir    <= aps_pkg::DIR_NONE;
      q_dir      <= aps_pkg::DIR_NONE;
      cur_phase  <= aps_pkg::PH_NONE;
      last_cond  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      start_time <= start_time_next;
      prog       <= prog_next;
      cur_dir    <= cur_dir_next;
      q_dir      <= q_dir_next;
      cur_phase  <= cur_phase_next;
      last_cond  <= last_cond_next;
      if (state == aps_pkg::SEQ_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r       <= now_ms;
      start_req_r <= start_request;
    end
    if (state == aps_pkg::SEQ_FINISH && out_free) begin
      direction <= cur_dir;
      phase     <= cur_phase;
      progress  <= prog;
      queued    <= q_dir;
    end
  end

  `APS_ASSERT_NOW(a_prog_max, clk, rst, 1'b1, prog <= ONE, "progress above one")
  `APS_ASSERT_NOW(a_done_wait, clk, rst, adone, arith_wait, "arith done outside wait state")
  `APS_ASSERT_NOW(a_start_src, clk, rst, areq.start, arith_issue, "arith start from wrong state")
  `APS_ASSERT_NEXT(a_out_load, clk, rst, out_load, out_valid && !in_stall, "result not loaded")

endmodule

### hdl/animation_progress_sequencer_top.sv
// Top level of the animation progress sequencer: configuration registers and
// the sequencer with its shared arithmetic unit. Depends on aps_pkg, aps_sequencer and aps_arith_unit.
`timescale 1ns / 1ps

// Condition, queue, retire and reset transactions go from acceptance straight
// to the finish state, where the result is registered once the output is free.
// A tick runs up to two bit-serial passes on the one shared adder: a re-base
// multiply when the direction turns and a divide for the ramp value.
// One transaction is in work at a time.

module animation_progress_sequencer_top #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [aps_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                operation,
  input  logic [31:0]               now_ms,
  input  logic                      start_request,
  input  logic                      condition,
  input  logic [1:0]                queue_direction,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                direction,
  output logic [1:0]                phase,
  output logic [FRACTION_BITS:0]    progress,
  output logic [1:0]                queued
);

  logic [aps_pkg::LEN_W-1:0] run_length;
  logic [aps_pkg::LEN_W-1:0] start_delay;
  aps_pkg::repeat_t          repeat_mode;
  logic                      reversible;

  aps_pkg::arith_req_t       areq;
  logic [FRACTION_BITS:0]    frac_in;
  logic [aps_pkg::LEN_W-1:0] num_in;
  logic                      adone;
  logic [aps_pkg::LEN_W-1:0] product;
  logic [FRACTION_BITS:0]    quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_length  <= '0;
      start_delay <= '0;
      repeat_mode <= aps_pkg::REP_NONE;
      reversible  <= 1'b1;
    end else if (cfg_write) begin
      case (aps_pkg::cfg_reg_t'(cfg_index))
        aps_pkg::REG_RUN_LENGTH:  run_length  <= cfg_data[aps_pkg::LEN_W-1:0];
        aps_pkg::REG_START_DELAY: start_delay <= cfg_data[aps_pkg::LEN_W-1:0];
        aps_pkg::REG_REPEAT_MODE: repeat_mode <= aps_pkg::repeat_t'(cfg_data[1:0]);
        aps_pkg::REG_REVERSIBLE:  reversible  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  aps_sequencer #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .now_ms          (now_ms),
    .start_request   (start_request),
    .condition       (condition),
    .queue_direction (queue_direction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .direction       (direction),
    .phase           (phase),
    .progress        (progress),
    .queued          (queued),
    .run_length      (run_length),
    .start_delay     (start_delay),
    .repeat_mode     (repeat_mode),
    .reversible      (reversible),
    .areq            (areq),
    .frac_in         (frac_in),
    .num_in          (num_in),
    .adone           (adone),
    .product         (product),
    .quotient        (quotient)
  );

  aps_arith_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_arith (
    .clk      (clk),
    .rst      (rst),
    .req      (areq),
    .len      (run_length),
    .frac_in  (frac_in),
    .num_in   (num_in),
    .done     (adone),
    .product  (product),
    .quotient (quotient)
  );

endmodule
